FILE: rtl/lpmr_pkg.sv
// ---------------------------------------------------------------------------
// Length-prefixed message ring: shared package
// Sizes, status codes and the controller/datapath command and status types.
// ---------------------------------------------------------------------------
`default_nettype none

package lpmr_pkg;

  localparam int RING_DEPTH  = 1024;
  localparam int PTR_W       = $clog2(RING_DEPTH);
  localparam int DATA_W      = 64;
  localparam int LEN_W       = 10;
  localparam int RING_W      = 11;
  localparam int CNT_W       = 10;
  localparam int STAT_W      = 3;
  localparam int IN_TDATA_W  = 80;
  localparam int OUT_TDATA_W = 96;
  localparam int NXT_W       = (PTR_W + 1 > RING_W) ? PTR_W + 1 : RING_W;

  localparam logic [RING_W-1:0] RING_WORDS_MIN = RING_W'(2);
  localparam logic [RING_W-1:0] RING_WORDS_MAX =
    (RING_DEPTH > 2047) ? RING_W'(2047) : RING_W'(RING_DEPTH);
  localparam logic [RING_W-1:0] RING_WORDS_RST =
    (RING_DEPTH > 1024) ? RING_W'(1024) : RING_WORDS_MAX;

  localparam logic [STAT_W-1:0] ST_OK      = 3'd0;
  localparam logic [STAT_W-1:0] ST_EMPTY   = 3'd1;
  localparam logic [STAT_W-1:0] ST_NOSPACE = 3'd2;
  localparam logic [STAT_W-1:0] ST_TOOBIG  = 3'd3;
  localparam logic [STAT_W-1:0] ST_DROPPED = 3'd4;

  localparam logic OP_SEND = 1'b0;
  localparam logic OP_RECV = 1'b1;

  typedef struct packed {
    logic capture;
    logic send_step;
    logic send_data;
    logic recv_empty;
    logic hdr_read;
    logic hdr_check;
    logic recv_issue;
    logic recv_data;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic op;
    logic send_reserve;
    logic recv_active;
    logic count_zero;
    logic hdr_done;
  } dp_status_t;

endpackage

`default_nettype wire

FILE: rtl/lpmr_ram.sv
// ---------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port with registered read data.
// ---------------------------------------------------------------------------
`default_nettype none

module lpmr_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 1024
) (
  input  wire                     clk,
  input  wire                     we,
  input  wire [$clog2(DEPTH)-1:0] waddr,
  input  wire [WIDTH-1:0]         wdata,
  input  wire                     re,
  input  wire [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]        rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

FILE: rtl/lpmr_ctrl.sv
// ---------------------------------------------------------------------------
// Length-prefixed message ring: controller
// Sequences one beat at a time through the datapath and owns both handshakes.
// ---------------------------------------------------------------------------
`default_nettype none

module lpmr_ctrl (
  input  wire                 clk,
  input  wire                 rst,
  input  wire                 s_tvalid,
  output logic                s_tready,
  output logic                m_tvalid,
  input  wire                 m_tready,
  input  wire lpmr_pkg::dp_status_t st,
  output lpmr_pkg::cmd_t      cmd
);

  localparam logic [2:0] S_IDLE      = 3'd0;
  localparam logic [2:0] S_EXEC      = 3'd1;
  localparam logic [2:0] S_SEND_DATA = 3'd2;
  localparam logic [2:0] S_RD_HDR    = 3'd3;
  localparam logic [2:0] S_RD_ISSUE  = 3'd4;
  localparam logic [2:0] S_RD_DATA   = 3'd5;
  localparam logic [2:0] S_DONE      = 3'd6;

  logic [2:0] state;
  logic [2:0] state_next;

  assign s_tready = (state == S_IDLE) && (!m_tvalid || m_tready);

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (s_tvalid && s_tready) begin
          cmd.capture = 1'b1;
          state_next  = S_EXEC;
        end
      end
      S_EXEC: begin
        if (st.op == lpmr_pkg::OP_SEND) begin
          cmd.send_step = 1'b1;
          state_next    = st.send_reserve ? S_SEND_DATA : S_DONE;
        end else if (st.recv_active) begin
          cmd.recv_issue = 1'b1;
          state_next     = S_RD_DATA;
        end else if (st.count_zero) begin
          cmd.recv_empty = 1'b1;
          state_next     = S_DONE;
        end else begin
          cmd.hdr_read = 1'b1;
          state_next   = S_RD_HDR;
        end
      end
      S_SEND_DATA: begin
        cmd.send_data = 1'b1;
        state_next    = S_DONE;
      end
      S_RD_HDR: begin
        cmd.hdr_check = 1'b1;
        state_next    = st.hdr_done ? S_DONE : S_RD_ISSUE;
      end
      S_RD_ISSUE: begin
        cmd.recv_issue = 1'b1;
        state_next     = S_RD_DATA;
      end
      S_RD_DATA: begin
        cmd.recv_data = 1'b1;
        state_next    = S_DONE;
      end
      S_DONE: begin
        cmd.finish = 1'b1;
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.finish) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // A finished result must never overwrite one still waiting at the output.
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.finish |-> (!m_tvalid || m_tready))
    else $error("result finished while output register still full");

  // Only one item is in flight: no beat is taken outside the idle state.
  a_accept_idle: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> (state == S_EXEC))
    else $error("accepted beat did not start execution");

  // Every accepted item reaches the output stage.
  a_bounded: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |-> ##5 (state == S_DONE || state == S_IDLE ||
                                      $past(state) == S_DONE ||
                                      $past(state, 2) == S_DONE ||
                                      $past(state, 3) == S_DONE))
    else $error("item did not complete in time");

endmodule

`default_nettype wire

FILE: rtl/lpmr_dp.sv
// ---------------------------------------------------------------------------
// Length-prefixed message ring: datapath
// Ring store, pointers, counters, result assembly and the output register.
// ---------------------------------------------------------------------------
`default_nettype none

module lpmr_dp (
  input  wire                                clk,
  input  wire                                rst,
  input  wire                                cfg_wr_en,
  input  wire [lpmr_pkg::RING_W-1:0]         cfg_wr_data,
  input  wire                                in_op,
  input  wire [lpmr_pkg::DATA_W-1:0]         in_data,
  input  wire [lpmr_pkg::LEN_W-1:0]          in_words,
  input  wire lpmr_pkg::cmd_t                cmd,
  output lpmr_pkg::dp_status_t               st,
  output logic [lpmr_pkg::STAT_W-1:0]        out_status,
  output logic [lpmr_pkg::DATA_W-1:0]        out_data,
  output logic                               out_last,
  output logic [lpmr_pkg::LEN_W-1:0]         out_len,
  output logic [lpmr_pkg::CNT_W-1:0]         out_count,
  output logic [lpmr_pkg::RING_W-1:0]        out_free
);

  logic [lpmr_pkg::RING_W-1:0] ring_words;
  logic [lpmr_pkg::PTR_W-1:0]  rp;
  logic [lpmr_pkg::PTR_W-1:0]  wp;
  logic [lpmr_pkg::CNT_W-1:0]  msg_count;
  logic [lpmr_pkg::RING_W-1:0] free_count;
  logic [lpmr_pkg::LEN_W-1:0]  send_rem;
  logic [lpmr_pkg::LEN_W-1:0]  recv_rem;
  logic [lpmr_pkg::LEN_W-1:0]  recv_length;
  logic                        dropping;

  logic                        op;
  logic [lpmr_pkg::DATA_W-1:0] data;
  logic [lpmr_pkg::LEN_W-1:0]  words;

  logic [lpmr_pkg::STAT_W-1:0] res_status;
  logic [lpmr_pkg::DATA_W-1:0] res_data;
  logic                        res_last;
  logic [lpmr_pkg::LEN_W-1:0]  res_len;

  logic [lpmr_pkg::RING_W-1:0] cfg_words;
  logic [lpmr_pkg::RING_W-1:0] need;
  logic                        no_space;
  logic [lpmr_pkg::PTR_W-1:0]  rp_inc;
  logic [lpmr_pkg::PTR_W-1:0]  wp_inc;
  logic [lpmr_pkg::DATA_W-1:0] rdata;
  logic [lpmr_pkg::LEN_W-1:0]  hdr;
  logic                        too_big;
  logic [lpmr_pkg::RING_W:0]   free_sum;
  logic [lpmr_pkg::RING_W-1:0] free_rel;
  logic                        store_data;
  logic                        ram_we;
  logic [lpmr_pkg::DATA_W-1:0] ram_wdata;

  function automatic logic [lpmr_pkg::PTR_W-1:0] next_index(
    input logic [lpmr_pkg::PTR_W-1:0]  p,
    input logic [lpmr_pkg::RING_W-1:0] size
  );
    logic [lpmr_pkg::NXT_W-1:0] n;
    n = lpmr_pkg::NXT_W'(p) + lpmr_pkg::NXT_W'(1);
    return (n >= lpmr_pkg::NXT_W'(size)) ? '0 : n[lpmr_pkg::PTR_W-1:0];
  endfunction

  always_comb begin
    if (cfg_wr_data < lpmr_pkg::RING_WORDS_MIN) begin
      cfg_words = lpmr_pkg::RING_WORDS_MIN;
    end else if (cfg_wr_data > lpmr_pkg::RING_WORDS_MAX) begin
      cfg_words = lpmr_pkg::RING_WORDS_MAX;
    end else begin
      cfg_words = cfg_wr_data;
    end
  end

  assign need     = lpmr_pkg::RING_W'(words) + lpmr_pkg::RING_W'(1);
  assign no_space = free_count < need;
  assign rp_inc   = next_index(rp, ring_words);
  assign wp_inc   = next_index(wp, ring_words);
  assign hdr      = rdata[lpmr_pkg::LEN_W-1:0];
  assign too_big  = words < hdr;
  assign free_sum = {1'b0, free_count} + (lpmr_pkg::RING_W + 1)'(recv_length)
                    + (lpmr_pkg::RING_W + 1)'(1);
  assign free_rel = (free_sum > {1'b0, ring_words}) ? ring_words
                    : free_sum[lpmr_pkg::RING_W-1:0];

  assign st.op           = op;
  assign st.send_reserve = !dropping && (send_rem == '0) && (words != '0) && !no_space;
  assign st.recv_active  = recv_rem != '0;
  assign st.count_zero   = msg_count == '0;
  assign st.hdr_done     = too_big || (hdr == '0);

  assign store_data = cmd.send_step && !dropping && (send_rem != '0);
  assign ram_we     = store_data || (cmd.send_step && st.send_reserve) || cmd.send_data;
  assign ram_wdata  = (cmd.send_step && st.send_reserve)
                      ? lpmr_pkg::DATA_W'(words) : data;

  lpmr_ram #(
    .WIDTH(lpmr_pkg::DATA_W),
    .DEPTH(lpmr_pkg::RING_DEPTH)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(wp),
    .wdata(ram_wdata),
    .re   (cmd.hdr_read || cmd.recv_issue),
    .raddr(rp),
    .rdata(rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      ring_words  <= lpmr_pkg::RING_WORDS_RST;
      free_count  <= lpmr_pkg::RING_WORDS_RST;
      rp          <= '0;
      wp          <= '0;
      msg_count   <= '0;
      send_rem    <= '0;
      recv_rem    <= '0;
      recv_length <= '0;
      dropping    <= 1'b0;
    end else if (cfg_wr_en) begin
      ring_words  <= cfg_words;
      free_count  <= cfg_words;
      rp          <= '0;
      wp          <= '0;
      msg_count   <= '0;
      send_rem    <= '0;
      recv_rem    <= '0;
      recv_length <= '0;
      dropping    <= 1'b0;
    end else begin
      if (cmd.send_step) begin
        if (dropping) begin
          if (send_rem != '0) begin
            send_rem <= send_rem - 1'b1;
          end
          if (send_rem <= lpmr_pkg::LEN_W'(1)) begin
            dropping <= 1'b0;
          end
        end else if (send_rem != '0) begin
          wp       <= wp_inc;
          send_rem <= send_rem - 1'b1;
          if (send_rem == lpmr_pkg::LEN_W'(1)) begin
            msg_count <= msg_count + 1'b1;
          end
        end else if (words == '0) begin
          dropping <= 1'b0;
        end else if (no_space) begin
          if (words > lpmr_pkg::LEN_W'(1)) begin
            dropping <= 1'b1;
            send_rem <= words - 1'b1;
          end
        end else begin
          free_count <= free_count - need;
          wp         <= wp_inc;
          send_rem   <= words - 1'b1;
        end
      end
      if (cmd.send_data) begin
        wp <= wp_inc;
        if (send_rem == '0) begin
          msg_count <= msg_count + 1'b1;
        end
      end
      if (cmd.hdr_check && !too_big) begin
        recv_length <= hdr;
        recv_rem    <= hdr;
        rp          <= rp_inc;
        if (hdr == '0) begin
          msg_count  <= msg_count - 1'b1;
          free_count <= free_count + 1'b1;
        end
      end
      if (cmd.recv_issue) begin
        rp <= rp_inc;
      end
      if (cmd.recv_data) begin
        recv_rem <= recv_rem - 1'b1;
        if (recv_rem == lpmr_pkg::LEN_W'(1)) begin
          msg_count  <= msg_count - 1'b1;
          free_count <= free_rel;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op         <= in_op;
      data       <= in_data;
      words      <= in_words;
      res_status <= lpmr_pkg::ST_OK;
      res_data   <= '0;
      res_last   <= 1'b0;
      res_len    <= '0;
    end
    if (cmd.send_step) begin
      if (dropping) begin
        res_status <= lpmr_pkg::ST_DROPPED;
        res_last   <= send_rem <= lpmr_pkg::LEN_W'(1);
      end else if (send_rem != '0) begin
        res_last <= send_rem == lpmr_pkg::LEN_W'(1);
      end else if (words == '0) begin
        res_status <= lpmr_pkg::ST_DROPPED;
        res_last   <= 1'b1;
      end else if (no_space) begin
        res_status <= lpmr_pkg::ST_NOSPACE;
        res_last   <= words <= lpmr_pkg::LEN_W'(1);
      end
    end
    if (cmd.send_data) begin
      res_last <= send_rem == '0;
    end
    if (cmd.recv_empty) begin
      res_status <= lpmr_pkg::ST_EMPTY;
    end
    if (cmd.hdr_check) begin
      if (too_big) begin
        res_status <= lpmr_pkg::ST_TOOBIG;
        res_len    <= hdr;
      end else if (hdr == '0) begin
        res_last <= 1'b1;
      end
    end
    if (cmd.recv_data) begin
      res_data <= rdata;
      res_len  <= recv_length;
      res_last <= recv_rem == lpmr_pkg::LEN_W'(1);
    end
    if (cmd.finish) begin
      out_status <= res_status;
      out_data   <= res_data;
      out_last   <= res_last;
      out_len    <= res_len;
      out_count  <= msg_count;
      out_free   <= free_count;
    end
  end

  // The free count never exceeds the configured ring size.
  a_free_bound: assert property (@(posedge clk) disable iff (rst)
    free_count <= ring_words)
    else $error("free count exceeds ring size");

  // Both pointers stay inside the configured ring.
  a_ptr_bound: assert property (@(posedge clk) disable iff (rst)
    (lpmr_pkg::NXT_W'(rp) < lpmr_pkg::NXT_W'(ring_words)) &&
    (lpmr_pkg::NXT_W'(wp) < lpmr_pkg::NXT_W'(ring_words)))
    else $error("ring pointer out of range");

  // A dropped message always has words left to swallow.
  a_drop_rem: assert property (@(posedge clk) disable iff (rst)
    dropping |-> (send_rem != '0))
    else $error("dropping with no words remaining");

  // A header is only fetched when a whole message is queued.
  a_hdr_queued: assert property (@(posedge clk) disable iff (rst)
    cmd.hdr_read |-> (msg_count != '0) && (recv_rem == '0))
    else $error("header read with nothing queued");

endmodule

`default_nettype wire

FILE: rtl/length_prefixed_message_ring_core.sv
// ---------------------------------------------------------------------------
// Length-prefixed message ring core
// Variable-length message queue in a ring of 64-bit words.
// ---------------------------------------------------------------------------
// Input beats arrive on the s_ channel: s_tuser selects send (0) or receive
// (1), s_tdata carries the data word and the message length or receiver
// capacity. Each beat produces exactly one result beat on the m_ channel with
// a status in m_tuser, the received word, the message length, the queued
// message count and the free word count in m_tdata, and m_tlast at the end of
// a sent or received message.
// One beat is worked on at a time. A plain send, a dropped word or an empty
// receive passes through execute and done; the first word of a stored message
// adds a data write, a continuing receive a data read, and a too-large receive
// a header read and check; the first word of a receive reads the header and
// then the data through the ring RAM's registered port. The result is registered
// in the done state. A held result does not block acceptance of the next beat
// when it is taken in the same cycle; otherwise s_tready stays low until
// m_tready takes it. Reset, or a write on the configuration port, empties the
// queue and sets the ring size; the ring RAM itself is not cleared.
// ---------------------------------------------------------------------------
`default_nettype none

module length_prefixed_message_ring_core (
  input  wire         clk,
  input  wire         rst,
  input  wire         cfg_wr_en,
  input  wire  [10:0] cfg_wr_data,  // ring_words
  input  wire         s_tvalid,
  output logic        s_tready,
  input  wire  [79:0] s_tdata,      // data_in[63:0], msg_words[73:64], zero pad
  input  wire         s_tuser,      // operation
  output logic        m_tvalid,
  input  wire         m_tready,
  output logic [95:0] m_tdata,      // data_out, msg_len_out, queued_messages,
                                    // free_space, zero pad
  output logic [2:0]  m_tuser,      // status
  output logic        m_tlast
);

  lpmr_pkg::cmd_t       cmd;
  lpmr_pkg::dp_status_t st;

  logic [lpmr_pkg::DATA_W-1:0] out_data;
  logic [lpmr_pkg::LEN_W-1:0]  out_len;
  logic [lpmr_pkg::CNT_W-1:0]  out_count;
  logic [lpmr_pkg::RING_W-1:0] out_free;

  lpmr_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .st      (st),
    .cmd     (cmd)
  );

  lpmr_dp u_dp (
    .clk        (clk),
    .rst        (rst),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_op      (s_tuser),
    .in_data    (s_tdata[63:0]),
    .in_words   (s_tdata[73:64]),
    .cmd        (cmd),
    .st         (st),
    .out_status (m_tuser),
    .out_data   (out_data),
    .out_last   (m_tlast),
    .out_len    (out_len),
    .out_count  (out_count),
    .out_free   (out_free)
  );

  assign m_tdata = {1'b0, out_free, out_count, out_len, out_data};

endmodule

`default_nettype wire
